/* hw/rtl/kyber_number_theoretic_transform_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, masked in reset.
// ----------------------------------------------------------------------------
`ifndef KYBER_NUMBER_THEORETIC_TRANSFORM_CORE_ASSERT_SVH
`define KYBER_NUMBER_THEORETIC_TRANSFORM_CORE_ASSERT_SVH

// same-cycle implication
`define KNTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KNTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/kntt_pkg.sv */
// ----------------------------------------------------------------------------
// kntt_pkg
// Types, codes and constants of the Kyber NTT core (q = 3329, n = 256).
// ----------------------------------------------------------------------------
package kntt_pkg;

  localparam int unsigned PolyLength    = 256;
  localparam int unsigned CoeffsPerItem = 4;
  localparam int unsigned AddrW         = $clog2(PolyLength);
  localparam int unsigned ItemW         = $clog2(PolyLength / CoeffsPerItem);

  localparam logic signed [15:0] InvScale  = 16'sd1441;
  localparam logic signed [15:0] BarrettV  = 16'sd20159;
  localparam logic signed [17:0] ModQ18    = 18'sd3329;
  localparam logic signed [33:0] ModQ34    = 34'sd3329;
  localparam logic [31:0]        QinvLow   = 32'd62209;

  localparam logic [1:0] MODE_FWD   = 2'd0;
  localparam logic [1:0] MODE_INV   = 2'd1;
  localparam logic [1:0] MODE_SCALE = 2'd2;

  localparam logic [1:0] WS_IN = 2'd0;
  localparam logic [1:0] WS_A  = 2'd1;
  localparam logic [1:0] WS_B  = 2'd2;

  localparam logic [1:0] MS_NONE = 2'd0;
  localparam logic [1:0] MS_1    = 2'd1;
  localparam logic [1:0] MS_2    = 2'd2;
  localparam logic [1:0] MS_3    = 2'd3;

  localparam logic signed [15:0] Zeta [128] = '{
    -16'sd1044, -16'sd758,  -16'sd359,  -16'sd1517, 16'sd1493,  16'sd1422,  16'sd287,   16'sd202,
    -16'sd171,  16'sd622,   16'sd1577,  16'sd182,   16'sd962,   -16'sd1202, -16'sd1474, 16'sd1468,
    16'sd573,   -16'sd1325, 16'sd264,   16'sd383,   -16'sd829,  16'sd1458,  -16'sd1602, -16'sd130,
    -16'sd681,  16'sd1017,  16'sd732,   16'sd608,   -16'sd1542, 16'sd411,   -16'sd205,  -16'sd1571,
    16'sd1223,  16'sd652,   -16'sd552,  16'sd1015,  -16'sd1293, 16'sd1491,  -16'sd282,  -16'sd1544,
    16'sd516,   -16'sd8,    -16'sd320,  -16'sd666,  -16'sd1618, -16'sd1162, 16'sd126,   16'sd1469,
    -16'sd853,  -16'sd90,   -16'sd271,  16'sd830,   16'sd107,   -16'sd1421, -16'sd247,  -16'sd951,
    -16'sd398,  16'sd961,   -16'sd1508, -16'sd725,  16'sd448,   -16'sd1065, 16'sd677,   -16'sd1275,
    -16'sd1103, 16'sd430,   16'sd555,   16'sd843,   -16'sd1251, 16'sd871,   16'sd1550,  16'sd105,
    16'sd422,   16'sd587,   16'sd177,   -16'sd235,  -16'sd291,  -16'sd460,  16'sd1574,  16'sd1653,
    -16'sd246,  16'sd778,   16'sd1159,  -16'sd147,  -16'sd777,  16'sd1483,  -16'sd602,  16'sd1119,
    -16'sd1590, 16'sd644,   -16'sd872,  16'sd349,   16'sd418,   16'sd329,   -16'sd156,  -16'sd75,
    16'sd817,   16'sd1097,  16'sd603,   16'sd610,   16'sd1322,  -16'sd1285, -16'sd1465, 16'sd384,
    -16'sd1215, -16'sd136,  16'sd1218,  -16'sd1335, -16'sd874,  16'sd220,   -16'sd1187, -16'sd1659,
    -16'sd1185, -16'sd1530, -16'sd1278, 16'sd794,   -16'sd1510, -16'sd854,  -16'sd870,  16'sd478,
    -16'sd108,  -16'sd308,  16'sd996,   16'sd991,   16'sd958,   -16'sd1460, 16'sd1522,  16'sd1628
  };

  typedef struct packed {
    logic signed [15:0] coeff_0;
    logic signed [15:0] coeff_1;
    logic signed [15:0] coeff_2;
    logic signed [15:0] coeff_3;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_coeff_0;
    logic signed [15:0] out_coeff_1;
    logic signed [15:0] out_coeff_2;
    logic signed [15:0] out_coeff_3;
    logic               final_group;
  } out_word_t;

  typedef struct packed {
    logic             in_cap;
    logic             wr_en;
    logic [1:0]       wr_sel;
    logic [1:0]       wr_lane;
    logic [AddrW-1:0] wr_addr;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr_a;
    logic [AddrW-1:0] rd_addr_b;
    logic [1:0]       mode;
    logic [6:0]       k;
    logic [1:0]       mul_step;
    logic             out_cap_lo;
    logic             out_cap_hi;
    logic             out_last;
  } dp_cmd_t;

endpackage

/* hw/rtl/kyber_number_theoretic_transform_core.sv */
// Input: accept plus four RAM writes per word; 64 words per polynomial.
// Transform: read, multiply steps and two writes per butterfly on one RAM with two
// read ports, 896 butterflies; the inverse then scales every coefficient in place.
// Output: read, captured, held valid until not stalled; 64 words, last one flagged.
// Reset (rst_ni low, asynchronous) clears sequencer, load count and direction;
// the coefficient RAM is not cleared.
// ----------------------------------------------------------------------------
// kyber_number_theoretic_transform_core
// Forward/inverse NTT over Z_3329 on a 256-coefficient polynomial.
// ----------------------------------------------------------------------------
`include "kyber_number_theoretic_transform_core_assert.svh"

module kyber_number_theoretic_transform_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kntt_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kntt_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);

  kntt_pkg::dp_cmd_t cmd;

  kntt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_o       (cmd)
  );

  kntt_datapath u_datapath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

  `KNTT_ASSERT_NXT(a_accept_blocks, in_valid_i && !in_stall_o, in_stall_o, "accept not followed by writes")
  `KNTT_ASSERT_IMP(a_out_excl_in, out_valid_o, in_stall_o, "input open while emitting")
  `KNTT_ASSERT_NXT(a_out_refill, out_valid_o && !out_stall_i, !out_valid_o, "word repeated")
  `KNTT_ASSERT_IMP(a_wr_only_busy, cmd.wr_en, in_stall_o, "RAM write while idle")

endmodule

/* hw/rtl/kntt_datapath.sv */
// ----------------------------------------------------------------------------
// kntt_datapath
// Coefficient RAM, butterfly arithmetic (Montgomery, Barrett) and word regs.
// ----------------------------------------------------------------------------
module kntt_datapath (
  input  logic                clk_i,
  input  kntt_pkg::dp_cmd_t   cmd_i,
  input  kntt_pkg::in_word_t  in_word_i,
  output kntt_pkg::out_word_t out_word_o
);

  logic signed [15:0] mem_q [kntt_pkg::PolyLength];
  logic signed [15:0] rd_a_q, rd_b_q;
  kntt_pkg::in_word_t  in_q;
  kntt_pkg::out_word_t out_q;

  logic signed [31:0] p_q;
  logic signed [15:0] u_q, m_q, s_q, bar_q;
  logic signed [5:0]  bt_q;

  logic signed [15:0] w, mx, my, sum_ab, diff_ba, wr_data, lane;
  logic signed [31:0] prod, bprod;
  logic [31:0]        uprod;
  logic signed [17:0] bt_mul;
  logic signed [33:0] t;

  assign w       = kntt_pkg::Zeta[cmd_i.k];
  assign sum_ab  = rd_a_q + rd_b_q;
  assign diff_ba = rd_b_q - rd_a_q;

  always_comb begin
    case (cmd_i.mode)
      kntt_pkg::MODE_INV: begin
        mx = w;
        my = diff_ba;
      end
      kntt_pkg::MODE_SCALE: begin
        mx = rd_a_q;
        my = kntt_pkg::InvScale;
      end
      default: begin
        mx = w;
        my = rd_b_q;
      end
    endcase
  end

  assign prod   = 32'(mx) * 32'(my);
  assign bprod  = 32'(sum_ab) * 32'(kntt_pkg::BarrettV);
  assign uprod  = 32'(p_q[15:0]) * kntt_pkg::QinvLow;
  assign bt_mul = 18'(bt_q) * kntt_pkg::ModQ18;
  assign t      = 34'(p_q) - 34'(u_q) * kntt_pkg::ModQ34;

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.mul_step)
      kntt_pkg::MS_1: begin
        p_q  <= prod;
        bt_q <= bprod[31:26];
        s_q  <= sum_ab;
      end
      kntt_pkg::MS_2: begin
        u_q   <= uprod[15:0];
        bar_q <= s_q - bt_mul[15:0];
      end
      kntt_pkg::MS_3: m_q <= t[31:16];
      default: ;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_lane)
      2'd0:    lane = in_q.coeff_0;
      2'd1:    lane = in_q.coeff_1;
      2'd2:    lane = in_q.coeff_2;
      default: lane = in_q.coeff_3;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      kntt_pkg::WS_A: begin
        case (cmd_i.mode)
          kntt_pkg::MODE_INV:   wr_data = bar_q;
          kntt_pkg::MODE_SCALE: wr_data = m_q;
          default:              wr_data = rd_a_q + m_q;
        endcase
      end
      kntt_pkg::WS_B: begin
        if (cmd_i.mode == kntt_pkg::MODE_FWD) begin
          wr_data = rd_a_q - m_q;
        end else begin
          wr_data = m_q;
        end
      end
      default: wr_data = lane;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_a_q <= mem_q[cmd_i.rd_addr_a];
      rd_b_q <= mem_q[cmd_i.rd_addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_cap) begin
      in_q <= in_word_i;
    end
    if (cmd_i.out_cap_lo) begin
      out_q.out_coeff_0 <= rd_a_q;
      out_q.out_coeff_1 <= rd_b_q;
    end
    if (cmd_i.out_cap_hi) begin
      out_q.out_coeff_2 <= rd_a_q;
      out_q.out_coeff_3 <= rd_b_q;
      out_q.final_group <= cmd_i.out_last;
    end
  end

  assign out_word_o = out_q;

endmodule

/* hw/rtl/kntt_ctrl.sv */
// ----------------------------------------------------------------------------
// kntt_ctrl
// Sequencer: load, butterfly layers, inverse scaling and word output.
// ----------------------------------------------------------------------------
module kntt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  output kntt_pkg::dp_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_M1    = 4'd3;
  localparam logic [3:0] S_M2    = 4'd4;
  localparam logic [3:0] S_M3    = 4'd5;
  localparam logic [3:0] S_WA    = 4'd6;
  localparam logic [3:0] S_WB    = 4'd7;
  localparam logic [3:0] S_ORD0  = 4'd8;
  localparam logic [3:0] S_ORD1  = 4'd9;
  localparam logic [3:0] S_OCAP  = 4'd10;
  localparam logic [3:0] S_OWAIT = 4'd11;

  logic [3:0] state_q, state_d;
  logic       dir_q;
  logic [kntt_pkg::ItemW-1:0] load_cnt_q, load_cnt_d;
  logic [1:0] lane_q, lane_d;
  logic [1:0] mode_q, mode_d;
  logic [2:0] shift_q, shift_d;
  logic [7:0] cnt_q, cnt_d;

  logic [7:0] grp, rem, idx_a, span, k_fwd, k_inv;
  logic       bf_last, item_last;

  assign span    = 8'd1 << shift_q;
  assign grp     = {1'b0, cnt_q[6:0]} >> shift_q;
  assign rem     = {1'b0, cnt_q[6:0]} & (span - 8'd1);
  assign idx_a   = (grp << (shift_q + 3'd1)) | rem;
  assign k_fwd   = (8'd128 >> shift_q) + grp;
  assign k_inv   = 8'((9'd256 >> shift_q) - 9'd1 - {1'b0, grp});
  assign bf_last = (cnt_q[6:0] == 7'd127);
  assign item_last = (cnt_q[5:0] == 6'd63);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (cfg_we_i) begin
      dir_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    lane_d     = lane_q;
    mode_d     = mode_q;
    shift_d    = shift_q;
    cnt_d      = cnt_q;

    cmd_o            = '0;
    cmd_o.mode       = mode_q;
    cmd_o.k          = (mode_q == kntt_pkg::MODE_INV) ? k_inv[6:0] : k_fwd[6:0];
    cmd_o.wr_lane    = lane_q;
    cmd_o.wr_sel     = kntt_pkg::WS_IN;
    cmd_o.mul_step   = kntt_pkg::MS_NONE;
    cmd_o.out_last   = item_last;
    if (mode_q == kntt_pkg::MODE_SCALE) begin
      cmd_o.rd_addr_a = cnt_q;
      cmd_o.rd_addr_b = cnt_q;
    end else begin
      cmd_o.rd_addr_a = idx_a;
      cmd_o.rd_addr_b = idx_a + span;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_cap = 1'b1;
          lane_d       = 2'd0;
          state_d      = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = {load_cnt_q, lane_q};
        lane_d        = lane_q + 2'd1;
        if (lane_q == 2'd3) begin
          load_cnt_d = load_cnt_q + kntt_pkg::ItemW'(1);
          state_d    = S_IDLE;
          if (load_cnt_q == kntt_pkg::ItemW'(6'd63)) begin
            cnt_d = '0;
            if (dir_q) begin
              mode_d  = kntt_pkg::MODE_INV;
              shift_d = 3'd1;
            end else begin
              mode_d  = kntt_pkg::MODE_FWD;
              shift_d = 3'd7;
            end
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_M1;
      end
      S_M1: begin
        cmd_o.mul_step = kntt_pkg::MS_1;
        state_d        = S_M2;
      end
      S_M2: begin
        cmd_o.mul_step = kntt_pkg::MS_2;
        state_d        = S_M3;
      end
      S_M3: begin
        cmd_o.mul_step = kntt_pkg::MS_3;
        state_d        = S_WA;
      end
      S_WA: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = kntt_pkg::WS_A;
        cmd_o.wr_addr = cmd_o.rd_addr_a;
        if (mode_q == kntt_pkg::MODE_SCALE) begin
          cnt_d   = cnt_q + 8'd1;
          state_d = S_RD;
          if (cnt_q == 8'd255) begin
            cnt_d   = '0;
            state_d = S_ORD0;
          end
        end else begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = kntt_pkg::WS_B;
        cmd_o.wr_addr = cmd_o.rd_addr_b;
        cnt_d         = {1'b0, cnt_q[6:0] + 7'd1};
        state_d       = S_RD;
        if (bf_last) begin
          if (mode_q == kntt_pkg::MODE_FWD) begin
            if (shift_q == 3'd1) begin
              state_d = S_ORD0;
            end else begin
              shift_d = shift_q - 3'd1;
            end
          end else if (shift_q == 3'd7) begin
            mode_d = kntt_pkg::MODE_SCALE;
          end else begin
            shift_d = shift_q + 3'd1;
          end
        end
      end
      S_ORD0: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_addr_a = {cnt_q[5:0], 2'd0};
        cmd_o.rd_addr_b = {cnt_q[5:0], 2'd1};
        state_d         = S_ORD1;
      end
      S_ORD1: begin
        cmd_o.rd_en      = 1'b1;
        cmd_o.rd_addr_a  = {cnt_q[5:0], 2'd2};
        cmd_o.rd_addr_b  = {cnt_q[5:0], 2'd3};
        cmd_o.out_cap_lo = 1'b1;
        state_d          = S_OCAP;
      end
      S_OCAP: begin
        cmd_o.out_cap_hi = 1'b1;
        state_d          = S_OWAIT;
      end
      S_OWAIT: begin
        if (!out_stall_i) begin
          cnt_d   = {2'd0, cnt_q[5:0] + 6'd1};
          state_d = item_last ? S_IDLE : S_ORD0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      load_cnt_q <= '0;
      lane_q     <= '0;
      mode_q     <= kntt_pkg::MODE_FWD;
      shift_q    <= 3'd7;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      lane_q     <= lane_d;
      mode_q     <= mode_d;
      shift_q    <= shift_d;
      cnt_q      <= cnt_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OWAIT);

endmodule

/* dv/tb_kyber_number_theoretic_transform_core.sv */
// ----------------------------------------------------------------------------
// tb_kyber_number_theoretic_transform_core
// Loads polynomials word by word, predicts the forward or inverse NTT of each
// and checks every output word in order, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_kyber_number_theoretic_transform_core;

  localparam int WordsPerPoly = kntt_pkg::PolyLength / kntt_pkg::CoeffsPerItem;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  kntt_pkg::in_word_t  in_word_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  kntt_pkg::out_word_t out_word_o;
  logic                cfg_we_i = 1'b0;
  logic                cfg_wdata_i = 1'b0;

  kyber_number_theoretic_transform_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o, .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic signed [15:0]  poly_q[kntt_pkg::PolyLength];
  int                  words_loaded;
  logic                direction;
  kntt_pkg::out_word_t expected_words[$];
  int                  errors;
  int                  burst_left;
  int                  stall_mode;

  function automatic logic signed [15:0] floor_shr(logic signed [63:0] x, int s);
    return 16'(x >>> s);
  endfunction

  function automatic logic signed [15:0] mont_reduce(logic signed [31:0] a);
    logic signed [15:0] u;
    logic signed [63:0] t;
    u = 16'(a * 32'sd62209);
    t = 64'(a) - 64'(u) * 64'sd3329;
    return floor_shr(t, 16);
  endfunction

  function automatic logic signed [15:0] mont_product(logic signed [15:0] a,
                                                        logic signed [15:0] b);
    return mont_reduce(32'(a) * 32'(b));
  endfunction

  function automatic logic signed [15:0] barrett(logic signed [15:0] a);
    logic signed [63:0] t;
    logic signed [15:0] qt;
    t = (64'sd20159 * 64'(a)) >>> 26;
    qt = 16'(t * 64'sd3329);
    return a - qt;
  endfunction

  task automatic transform_poly();
    int k;
    logic signed [15:0] w, m, lo;
    if (!direction) begin
      k = 1;
      for (int span = 128; span >= 2; span >>= 1)
        for (int b = 0; b < 256; b += 2 * span) begin
          w = kntt_pkg::Zeta[k & 127];
          k++;
          for (int i = b; i < b + span; i++) begin
            m = mont_product(w, poly_q[i + span]);
            poly_q[i + span] = poly_q[i] - m;
            poly_q[i] = poly_q[i] + m;
          end
        end
    end else begin
      k = 127;
      for (int span = 2; span <= 128; span <<= 1)
        for (int b = 0; b < 256; b += 2 * span) begin
          w = kntt_pkg::Zeta[k & 127];
          k--;
          for (int i = b; i < b + span; i++) begin
            lo = poly_q[i];
            poly_q[i] = barrett(lo + poly_q[i + span]);
            poly_q[i + span] = mont_product(w, poly_q[i + span] - lo);
          end
        end
      for (int i = 0; i < 256; i++) poly_q[i] = mont_product(poly_q[i], kntt_pkg::InvScale);
    end
  endtask

  task automatic predict_word(kntt_pkg::in_word_t wd);
    kntt_pkg::out_word_t o;
    int s;
    s = words_loaded * kntt_pkg::CoeffsPerItem;
    poly_q[s] = wd.coeff_0;
    poly_q[s + 1] = wd.coeff_1;
    poly_q[s + 2] = wd.coeff_2;
    poly_q[s + 3] = wd.coeff_3;
    words_loaded++;
    if (words_loaded == WordsPerPoly) begin
      words_loaded = 0;
      transform_poly();
      for (int j = 0; j < WordsPerPoly; j++) begin
        o.out_coeff_0 = poly_q[4 * j];
        o.out_coeff_1 = poly_q[4 * j + 1];
        o.out_coeff_2 = poly_q[4 * j + 2];
        o.out_coeff_3 = poly_q[4 * j + 3];
        o.final_group = (j == WordsPerPoly - 1);
        expected_words.push_back(o);
      end
    end
  endtask

  // send one word; bursts with random gaps
  task automatic send_word(kntt_pkg::in_word_t wd);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid_i <= 1'b1;
    in_word_i <= wd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(wd);
    burst_left--;
  endtask

  task automatic end_words();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
  endtask

  task automatic set_direction(logic d);
    while (in_stall_o) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    direction = d;
  endtask

  function automatic logic [15:0] rand_coeff(int kind);
    case (kind)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 6658)) - 3329);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_poly(int kind);
    kntt_pkg::in_word_t wd;
    for (int i = 0; i < WordsPerPoly; i++) begin
      wd.coeff_0 = rand_coeff(kind);
      wd.coeff_1 = rand_coeff(kind);
      wd.coeff_2 = rand_coeff(kind);
      wd.coeff_3 = rand_coeff(kind);
      send_word(wd);
    end
  endtask

  task automatic test_extremes();
    for (int d = 0; d < 2; d++) begin
      set_direction(d[0]);
      send_poly(0);
      send_poly(1);
      end_words();
      wait_drained();
    end
  endtask

  task automatic test_direction_mid_load();
    kntt_pkg::in_word_t wd;
    set_direction(1'b0);
    for (int i = 0; i < 10; i++) begin
      wd = {$urandom, $urandom};
      send_word(wd);
    end
    end_words();
    set_direction(1'b1);
    for (int i = 10; i < WordsPerPoly; i++) begin
      wd = {$urandom, $urandom};
      send_word(wd);
    end
    end_words();
    wait_drained();
  endtask

  task automatic test_random();
    for (int p = 0; p < 2; p++) begin
      set_direction(1'($urandom_range(0, 1)));
      send_poly($urandom_range(2, 3));
      end_words();
      wait_drained();
    end
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    kntt_pkg::out_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected output word %h", out_word_o);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_word_o.out_coeff_0 !== e.out_coeff_0) begin
          $error("out_coeff_0 exp %0d got %0d", e.out_coeff_0, out_word_o.out_coeff_0);
          errors++;
        end
        if (out_word_o.out_coeff_1 !== e.out_coeff_1) begin
          $error("out_coeff_1 exp %0d got %0d", e.out_coeff_1, out_word_o.out_coeff_1);
          errors++;
        end
        if (out_word_o.out_coeff_2 !== e.out_coeff_2) begin
          $error("out_coeff_2 exp %0d got %0d", e.out_coeff_2, out_word_o.out_coeff_2);
          errors++;
        end
        if (out_word_o.out_coeff_3 !== e.out_coeff_3) begin
          $error("out_coeff_3 exp %0d got %0d", e.out_coeff_3, out_word_o.out_coeff_3);
          errors++;
        end
        if (out_word_o.final_group !== e.final_group) begin
          $error("final_group exp %0d got %0d", e.final_group, out_word_o.final_group);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    words_loaded = 0;
    direction = 1'b0;
    burst_left = 0;
    stall_mode = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_direction_mid_load();
    test_random();
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
